[rtl/qsnr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package qsnr_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int RAD_BITS  = 2 * WORD_BITS + 2;
    localparam int SQ_BITS   = RAD_BITS / 2;
    localparam int SREM_BITS = WORD_BITS + 5;
    localparam int NUM_BITS  = WORD_BITS + 3;
    localparam int QUO_BITS  = WORD_BITS + 2 + FRAC_BITS;
    localparam int DEN_BITS  = WORD_BITS + 1;
    localparam int DREM_BITS = WORD_BITS + 2;

    typedef struct packed {
        logic                        vld;
        logic                        none;
        logic                        a_neg;
        logic [WORD_BITS-1:0]        mag_a;
        logic signed [WORD_BITS-1:0] b;
        logic [RAD_BITS-1:0]         rad;
        logic [SREM_BITS-1:0]        rem;
        logic [SQ_BITS-1:0]          root;
    } t_sq;

    typedef struct packed {
        logic [DREM_BITS-1:0] r;
        logic [QUO_BITS-1:0]  nq;
    } t_lane;

    typedef struct packed {
        logic                vld;
        logic                none;
        logic                ok1;
        logic                ok2;
        logic [DEN_BITS-1:0] den;
        t_lane               lane1;
        t_lane               lane2;
    } t_dv;

    function automatic t_lane div_step(input t_lane l, input logic [DEN_BITS-1:0] den);
        logic [DREM_BITS:0] rt;
        logic [DREM_BITS:0] dx;
        logic               fits;
        t_lane              o;
        rt   = {l.r, l.nq[QUO_BITS-1]};
        dx   = {{(DREM_BITS + 1 - DEN_BITS){1'b0}}, den};
        fits = (rt >= dx);
        o.r  = fits ? DREM_BITS'(rt - dx) : rt[DREM_BITS-1:0];
        o.nq = {l.nq[QUO_BITS-2:0], fits};
        return o;
    endfunction

endpackage
`default_nettype wire

[rtl/qsnr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface qsnr_coef_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qsnr_pkg::WORD_BITS-1:0] coef_a;
    logic signed [qsnr_pkg::WORD_BITS-1:0] coef_b;
    logic signed [qsnr_pkg::WORD_BITS-1:0] coef_c;
    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qsnr_root_if;
    logic                          valid;
    logic                          ready;
    logic [qsnr_pkg::WORD_BITS-1:0] root_value;
    logic                          root_found;
    logic                          root_saturated;
    modport source (output valid, root_value, root_found, root_saturated, input ready);
    modport sink (input valid, root_value, root_found, root_saturated, output ready);
endinterface
`default_nettype wire

[rtl/quadratic_smallest_nonneg_root_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Smallest non-negative real root of a*t^2 + b*t + c on signed Q16.16 coefficients,
// returned as unsigned Q16.16 with found and saturated flags. Fully pipelined: one
// coefficient set per clock while no result waits at the output, built from one
// restoring square-root cell per root bit and one divider cell per quotient bit.
// The whole pipeline stalls only while a result waits at the output.
module quadratic_smallest_nonneg_root_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    qsnr_coef_if.sink        i_coef,
    qsnr_root_if.source      o_root
);
    localparam int W  = qsnr_pkg::WORD_BITS;
    localparam int SQ = qsnr_pkg::SQ_BITS;
    localparam int QW = qsnr_pkg::QUO_BITS;
    localparam int NW = qsnr_pkg::NUM_BITS;
    localparam int DW = qsnr_pkg::RAD_BITS;

    logic en;

    logic                r_s0_vld;
    logic signed [W-1:0] r_s0_a, r_s0_b, r_s0_c;

    logic                r_s1_vld, r_s1_a_neg, r_s1_c_neg, r_s1_a_zero;
    logic [W-1:0]        r_s1_ma;
    logic signed [W-1:0] r_s1_b;
    logic [2*W-1:0]      r_s1_bb, r_s1_ac;

    logic [W-1:0] ma, mb, mc;
    logic [DW-1:0] bb_x, ac4;

    qsnr_pkg::t_sq r_sq0, n_sq0;
    qsnr_pkg::t_sq w_sq [0:SQ];
    qsnr_pkg::t_dv r_dv0, n_dv0;
    qsnr_pkg::t_dv w_dv [0:QW];

    logic signed [NW-1:0] nb, sx, num1, num2;
    logic [NW-1:0]        mag1, mag2;

    logic          r_out_vld, r_found, r_sat;
    logic [W-1:0]  r_val;
    logic          n_found, n_sat;
    logic [W-1:0]  n_val;
    logic [QW-1:0] q1, q2, best;

    assign en           = !r_out_vld || o_root.ready;
    assign i_coef.ready = en;

    always_comb begin
        ma = r_s0_a[W-1] ? W'(-r_s0_a) : W'(r_s0_a);
        mb = r_s0_b[W-1] ? W'(-r_s0_b) : W'(r_s0_b);
        mc = r_s0_c[W-1] ? W'(-r_s0_c) : W'(r_s0_c);
    end

    always_comb begin
        bb_x = {2'b00, r_s1_bb};
        ac4  = {r_s1_ac, 2'b00};
        n_sq0       = '0;
        n_sq0.vld   = r_s1_vld;
        n_sq0.a_neg = r_s1_a_neg;
        n_sq0.mag_a = r_s1_ma;
        n_sq0.b     = r_s1_b;
        n_sq0.none  = r_s1_a_zero;
        if (r_s1_a_neg != r_s1_c_neg) begin
            n_sq0.rad = bb_x + ac4;
        end else begin
            if (bb_x < ac4) begin
                n_sq0.none = 1'b1;
            end
            n_sq0.rad = bb_x - ac4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_sq0.vld <= 1'b0;
        end else if (en) begin
            r_s0_vld    <= i_coef.valid;
            r_s0_a      <= i_coef.coef_a;
            r_s0_b      <= i_coef.coef_b;
            r_s0_c      <= i_coef.coef_c;
            r_s1_vld    <= r_s0_vld;
            r_s1_a_neg  <= r_s0_a[W-1];
            r_s1_c_neg  <= r_s0_c[W-1];
            r_s1_a_zero <= (r_s0_a == '0);
            r_s1_ma     <= ma;
            r_s1_b      <= r_s0_b;
            r_s1_bb     <= mb * mb;
            r_s1_ac     <= ma * mc;
            r_sq0       <= n_sq0;
        end
    end

    assign w_sq[0] = r_sq0;

    for (genvar g = 0; g < SQ; g++) begin : g_sqrt
        qsnr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_sq[g]),
            .o_q     (w_sq[g+1])
        );
    end

    always_comb begin
        nb   = -NW'(w_sq[SQ].b);
        sx   = $signed({{(NW - SQ){1'b0}}, w_sq[SQ].root});
        num1 = nb - sx;
        num2 = nb + sx;
        mag1 = num1[NW-1] ? NW'(-num1) : num1;
        mag2 = num2[NW-1] ? NW'(-num2) : num2;
        n_dv0          = '0;
        n_dv0.vld      = w_sq[SQ].vld;
        n_dv0.none     = w_sq[SQ].none;
        n_dv0.ok1      = (num1 == '0) || (num1[NW-1] == w_sq[SQ].a_neg);
        n_dv0.ok2      = (num2 == '0) || (num2[NW-1] == w_sq[SQ].a_neg);
        n_dv0.den      = {w_sq[SQ].mag_a, 1'b0};
        n_dv0.lane1.nq = QW'({mag1[NW-2:0], {qsnr_pkg::FRAC_BITS{1'b0}}});
        n_dv0.lane2.nq = QW'({mag2[NW-2:0], {qsnr_pkg::FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0.vld <= 1'b0;
        end else if (en) begin
            r_dv0 <= n_dv0;
        end
    end

    assign w_dv[0] = r_dv0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        qsnr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_dv[g]),
            .o_q     (w_dv[g+1])
        );
    end

    always_comb begin
        q1      = w_dv[QW].lane1.nq;
        q2      = w_dv[QW].lane2.nq;
        best    = q2;
        if (w_dv[QW].ok1 && (!w_dv[QW].ok2 || q1 <= q2)) begin
            best = q1;
        end
        n_found = !w_dv[QW].none && (w_dv[QW].ok1 || w_dv[QW].ok2);
        n_sat   = 1'b0;
        n_val   = '0;
        if (n_found) begin
            if (best[QW-1:W] != '0) begin
                n_sat = 1'b1;
                n_val = '1;
            end else begin
                n_val = best[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_dv[QW].vld;
            r_found   <= n_found;
            r_sat     <= n_sat;
            r_val     <= n_val;
        end
    end

    assign o_root.valid          = r_out_vld;
    assign o_root.root_value     = r_val;
    assign o_root.root_found     = r_found;
    assign o_root.root_saturated = r_sat;

    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_found) |-> (r_val == '0 && !r_sat))
        else $error("no-root result carries data");
    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_sat) |-> (r_found && r_val == '1))
        else $error("saturated result not clamped");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_vld)
        else $error("result valid after reset");
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_root.ready) |-> !i_coef.ready)
        else $error("input taken while pipeline stalled");
endmodule
`default_nettype wire

[rtl/qsnr_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module qsnr_sqrt_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  qsnr_pkg::t_sq   i_d,
    output qsnr_pkg::t_sq   o_q
);
    qsnr_pkg::t_sq                     r_q;
    qsnr_pkg::t_sq                     n_q;
    logic [qsnr_pkg::SREM_BITS-1:0]    rem_t;
    logic [qsnr_pkg::SREM_BITS-1:0]    trial;
    logic                              fits;

    always_comb begin
        rem_t = {i_d.rem[qsnr_pkg::SREM_BITS-3:0], i_d.rad[qsnr_pkg::RAD_BITS-1 -: 2]};
        trial = {{(qsnr_pkg::SREM_BITS - qsnr_pkg::SQ_BITS - 2){1'b0}}, i_d.root, 2'b01};
        fits  = (rem_t >= trial);
        n_q      = i_d;
        n_q.rem  = fits ? (rem_t - trial) : rem_t;
        n_q.root = {i_d.root[qsnr_pkg::SQ_BITS-2:0], fits};
        n_q.rad  = {i_d.rad[qsnr_pkg::RAD_BITS-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

[rtl/qsnr_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module qsnr_div_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  qsnr_pkg::t_dv   i_d,
    output qsnr_pkg::t_dv   o_q
);
    qsnr_pkg::t_dv r_q;
    qsnr_pkg::t_dv n_q;

    always_comb begin
        n_q       = i_d;
        n_q.lane1 = qsnr_pkg::div_step(i_d.lane1, i_d.den);
        n_q.lane2 = qsnr_pkg::div_step(i_d.lane2, i_d.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire
